FILE: rtl/ordered_unique_key_table_macros.svh
// ============================================================================
// Assertion macros for the ordered unique key table
// Shorthand for the concurrent checks that the table's top RTL module carries.
// ============================================================================
`ifndef ORDERED_UNIQUE_KEY_TABLE_MACROS_SVH
`define ORDERED_UNIQUE_KEY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OUKT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OUKT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/oukt_pkg.sv
// ============================================================================
// Ordered unique key table package
// Command and status codes and the fixed field widths of the request and response streams.
// ============================================================================
package oukt_pkg;

	localparam int CMD_W = 3;
	localparam int STAT_W = 3;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE_BACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TAKE_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd7;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_UNIQUE = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL       = 3'd4;

endpackage

FILE: rtl/oukt_store.sv
// ============================================================================
// Ordered unique key table entry store
// Circular single-port-read, single-port-write memory addressed by position
// in the list; the position is turned into a slot relative to the head.
// ============================================================================
module oukt_store #(
	parameter int CAPACITY = 64,
	parameter int DATA_W = 64
) (
	input  logic                              clk,
	input  logic [$clog2(CAPACITY)-1:0]       head,
	input  logic                              rd_en,
	input  logic [$clog2(CAPACITY+1)-1:0]     rd_idx,
	input  logic                              wr_en,
	input  logic [$clog2(CAPACITY+1)-1:0]     wr_idx,
	input  logic [DATA_W-1:0]                 wr_data,
	output logic [DATA_W-1:0]                 rd_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int SW = CW + 1;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [SW-1:0] rd_sum;
	logic [SW-1:0] wr_sum;
	logic [AW-1:0] rd_slot;
	logic [AW-1:0] wr_slot;

	// Position plus head, folded back once into the slot range.
	always_comb begin
		rd_sum = SW'(head) + SW'(rd_idx);
		wr_sum = SW'(head) + SW'(wr_idx);
		if (rd_sum >= SW'(CAPACITY)) begin
			rd_sum = rd_sum - SW'(CAPACITY);
		end
		if (wr_sum >= SW'(CAPACITY)) begin
			wr_sum = wr_sum - SW'(CAPACITY);
		end
		rd_slot = rd_sum[AW-1:0];
		wr_slot = wr_sum[AW-1:0];
	end

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_slot];
		end
	end

endmodule

FILE: rtl/ordered_unique_key_table.sv
// ============================================================================
// Ordered unique key table
// Bounded ordered list of key and value pairs with unique keys.
// ============================================================================
// Each request takes one command and yields one response. Entries live in a
// circular memory with one read and one write port, so every command that
// must find a key (both inserts, remove, lookup, contains) scans the list one
// entry per cycle, stopping early when the key is hit. A remove then closes
// the gap by moving each later entry down one place, one entry per cycle.
// Pops read the end entry and then commit it; clear, and a pop, remove or
// lookup on an empty table, go straight to the response. One request is
// handled at a time; the response register lets a new request be taken while
// the previous response waits on the output, and a response that cannot be
// handed over holds the block until the output is free.
module ordered_unique_key_table
	import oukt_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Fields from bit 0: command, item_key, item_value, zero fill.
	input  logic [((CMD_W+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// Fields from bit 0: status, found, result_key, result_value,
	// entry_count, zero fill.
	output logic [((STAT_W+1+KEY_BITS+VALUE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);

`include "ordered_unique_key_table_macros.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY+1);
	localparam int DW = KEY_BITS + VALUE_BITS;
	localparam int OUT_RAW = STAT_W + 1 + KEY_BITS + VALUE_BITS + CW;
	localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_POPW  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         rd_idx_q;
	logic                  pend_s1;
	logic [CW-1:0]         pend_idx_s1;
	logic [STAT_W-1:0]     res_status_q;
	logic                  res_found_q;
	logic [KEY_BITS-1:0]   res_key_q;
	logic [VALUE_BITS-1:0] res_val_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic [CMD_W-1:0]      in_cmd;
	logic [KEY_BITS-1:0]   in_key;
	logic [VALUE_BITS-1:0] in_val;
	logic                  accept;
	logic                  st_rd_en;
	logic [CW-1:0]         st_rd_idx;
	logic                  st_wr_en;
	logic [CW-1:0]         st_wr_idx;
	logic [DW-1:0]         st_wr_data;
	logic [DW-1:0]         st_rd_data;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  scan_hit;
	logic                  scan_miss;
	logic                  is_push;
	logic                  full;
	logic                  out_free;

	// Request unpacking and handshake.
	assign in_cmd = s_tdata[CMD_W-1:0];
	assign in_key = s_tdata[CMD_W +: KEY_BITS];
	assign in_val = s_tdata[CMD_W+KEY_BITS +: VALUE_BITS];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign out_free = !out_valid_q || m_tready;

	// Scan outcome and fixed conditions.
	assign rd_key = st_rd_data[KEY_BITS-1:0];
	assign rd_val = st_rd_data[DW-1:KEY_BITS];
	assign scan_hit = pend_s1 && (rd_key == key_q);
	assign scan_miss = !pend_s1 && (rd_idx_q == count_q);
	assign is_push = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PREPEND);
	assign full = (count_q == CW'(CAPACITY));

	// Memory port control. Every access is serialised by the sequencer, so a
	// read never meets a write to the same slot in flight.
	always_comb begin
		st_rd_en = 1'b0;
		st_rd_idx = rd_idx_q;
		st_wr_en = 1'b0;
		st_wr_idx = pend_idx_s1;
		st_wr_data = st_rd_data;
		unique case (state_q)
			ST_SCAN: begin
				st_rd_en = (rd_idx_q < count_q);
				if (!scan_hit && scan_miss && is_push && !full) begin
					st_wr_en = 1'b1;
					st_wr_data = {val_q, key_q};
					// One place before the head is the new front.
					st_wr_idx = (cmd_q == CMD_APPEND) ? count_q : CW'(CAPACITY - 1);
				end
			end
			ST_SHIFT: begin
				st_rd_en = (rd_idx_q < count_q);
				st_wr_en = pend_s1;
			end
			ST_POP: begin
				st_rd_en = 1'b1;
				st_rd_idx = (cmd_q == CMD_TAKE_BACK) ? count_q - CW'(1) : '0;
			end
			default: begin
			end
		endcase
	end

	oukt_store #(
		.CAPACITY(CAPACITY),
		.DATA_W(DW)
	) u_store (
		.clk(clk),
		.head(head_q),
		.rd_en(st_rd_en),
		.rd_idx(st_rd_idx),
		.wr_en(st_wr_en),
		.wr_idx(st_wr_idx),
		.wr_data(st_wr_data),
		.rd_data(st_rd_data)
	);

	// Request latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			val_q <= in_val;
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			rd_idx_q <= '0;
			pend_s1 <= 1'b0;
			pend_idx_s1 <= '0;
			res_status_q <= STAT_OK;
			res_found_q <= 1'b0;
			res_key_q <= '0;
			res_val_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						res_key_q <= '0;
						res_val_q <= '0;
						rd_idx_q <= '0;
						pend_s1 <= 1'b0;
						unique case (in_cmd)
							CMD_APPEND, CMD_PREPEND, CMD_CONTAINS: begin
								res_status_q <= STAT_OK;
								state_q <= ST_SCAN;
							end
							CMD_TAKE_BACK, CMD_TAKE_FRONT: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
									state_q <= ST_DONE;
								end else begin
									res_status_q <= STAT_OK;
									state_q <= ST_POP;
								end
							end
							CMD_REMOVE, CMD_LOOKUP: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
									state_q <= ST_DONE;
								end else begin
									res_status_q <= STAT_OK;
									state_q <= ST_SCAN;
								end
							end
							CMD_CLEAR: begin
								res_status_q <= STAT_OK;
								count_q <= '0;
								head_q <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// Compare the entry read last cycle while reading the next.
					pend_idx_s1 <= rd_idx_q;
					if (scan_hit && cmd_q == CMD_REMOVE) begin
						// Restart reading just past the hit to close the gap.
						rd_idx_q <= pend_idx_s1 + CW'(1);
						pend_s1 <= 1'b0;
					end else begin
						pend_s1 <= st_rd_en;
						if (st_rd_en) begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
					end
					if (scan_hit) begin
						if (is_push) begin
							res_status_q <= STAT_NOT_UNIQUE;
							state_q <= ST_DONE;
						end else begin
							res_found_q <= 1'b1;
							res_key_q <= rd_key;
							res_val_q <= rd_val;
							if (cmd_q == CMD_REMOVE) begin
								state_q <= ST_SHIFT;
							end else begin
								state_q <= ST_DONE;
							end
						end
					end else if (scan_miss) begin
						state_q <= ST_DONE;
						if (is_push) begin
							if (full) begin
								res_status_q <= STAT_FULL;
							end else begin
								count_q <= count_q + CW'(1);
								if (cmd_q == CMD_PREPEND) begin
									head_q <= (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
								end
							end
						end else if (cmd_q != CMD_CONTAINS) begin
							res_status_q <= STAT_NOT_FOUND;
						end
					end
				end
				ST_SHIFT: begin
					// Move each later entry down one place to close the gap.
					pend_s1 <= st_rd_en;
					pend_idx_s1 <= rd_idx_q - CW'(1);
					if (st_rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (!pend_s1 && rd_idx_q == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_POP: begin
					state_q <= ST_POPW;
				end
				ST_POPW: begin
					res_found_q <= 1'b1;
					res_key_q <= rd_key;
					res_val_q <= rd_val;
					count_q <= count_q - CW'(1);
					if (cmd_q == CMD_TAKE_FRONT) begin
						head_q <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= OUT_W'({count_q, res_val_q, res_key_q, res_found_q, res_status_q});
		end
	end

	`OUKT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "occupancy above capacity")
	`OUKT_ASSERT_NXT(a_clear_empties, accept && in_cmd == CMD_CLEAR, count_q == '0,
		"clear left entries")
	`OUKT_ASSERT_NXT(a_done_holds, state_q == ST_DONE && !out_free, state_q == ST_DONE,
		"response dropped while output busy")
	`OUKT_ASSERT_IMP(a_found_ok, m_tvalid && m_tdata[STAT_W], m_tdata[STAT_W-1:0] == STAT_OK,
		"found flagged with an error status")

endmodule
